/* sv/spct_pkg.sv */
package spct_pkg;

  // coordinate width of one center or half size value
  localparam int unsigned CoordBits = 20;
  // centers, half sizes and box bounds extended by two bits
  localparam int unsigned ExtBits   = CoordBits + 2;
  // per-axis distance, overlap and radius sum width
  localparam int unsigned DistBits  = CoordBits + 1;
  // squares and sums of squares
  localparam int unsigned SqBits    = 2 * CoordBits + 2;
  // packed half sizes x, y, z
  localparam int unsigned HalfBits  = 3 * CoordBits;

  typedef enum logic {
    SHAPE_BOX    = 1'b0,
    SHAPE_SPHERE = 1'b1
  } shape_e;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2,
    AXIS_Z    = 2'd3
  } axis_e;

endpackage

/* sv/shape_pair_collision_test.sv */
// shape pair collision test
//
// one transaction on the input channel carries two shapes (box or sphere),
// each a signed center and three packed half sizes, 8 fraction bits; one
// transaction on the output channel returns hit, penetration, normal axis
// and normal sign for that pair. penetration and normal are only nonzero
// on a box-box hit; sphere compares are exact integer compares on squares.
//
// the datapath is a four-stage pipeline: input register, difference stage,
// square stage, output register. one pair is accepted every cycle while the
// receiver takes results, since every stage can load in the same cycle that
// it hands its pair on.
//
// every stage loads when it is empty or the stage after it moves, so
// bubbles are squeezed out: while the receiver stalls, in_ready_o stays
// high until all four stages hold a pair, then drops.
// reset clears all stage valid bits; the data registers are not reset.
module shape_pair_collision_test
  import spct_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       type_a_i,
  input  logic signed [CoordBits-1:0] a_center_x_i,
  input  logic signed [CoordBits-1:0] a_center_y_i,
  input  logic signed [CoordBits-1:0] a_center_z_i,
  input  logic [HalfBits-1:0]        a_half_sizes_i,
  input  logic                       type_b_i,
  input  logic signed [CoordBits-1:0] b_center_x_i,
  input  logic signed [CoordBits-1:0] b_center_y_i,
  input  logic signed [CoordBits-1:0] b_center_z_i,
  input  logic [HalfBits-1:0]        b_half_sizes_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       hit_o,
  output logic [DistBits-1:0]        penetration_o,
  output logic [1:0]                 normal_axis_o,
  output logic                       normal_negative_o
);

  // ---------------------------------------------------------------------
  // pipeline control: a stage loads when empty or when its successor loads
  // ---------------------------------------------------------------------
  logic v0_q, v1_q, v2_q, v3_q;
  logic en0, en1, en2, en3;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;

  assign in_ready_o  = en0;
  assign out_valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // ---------------------------------------------------------------------
  // stage 0: input register
  // ---------------------------------------------------------------------
  logic                 s0_type_a_q, s0_type_b_q;
  logic [CoordBits-1:0] s0_ac_q [3];
  logic [CoordBits-1:0] s0_bc_q [3];
  logic [HalfBits-1:0]  s0_ah_q, s0_bh_q;

  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      s0_type_a_q <= type_a_i;
      s0_type_b_q <= type_b_i;
      s0_ac_q[0]  <= a_center_x_i;
      s0_ac_q[1]  <= a_center_y_i;
      s0_ac_q[2]  <= a_center_z_i;
      s0_bc_q[0]  <= b_center_x_i;
      s0_bc_q[1]  <= b_center_y_i;
      s0_bc_q[2]  <= b_center_z_i;
      s0_ah_q     <= a_half_sizes_i;
      s0_bh_q     <= b_half_sizes_i;
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: bounds, clamp, per-axis distance and box-box overlap
  // ---------------------------------------------------------------------
  logic s0_box_box, s0_sph_sph, s0_a_box;
  assign s0_box_box = (s0_type_a_q == SHAPE_BOX) && (s0_type_b_q == SHAPE_BOX);
  assign s0_sph_sph = (s0_type_a_q == SHAPE_SPHERE) && (s0_type_b_q == SHAPE_SPHERE);
  assign s0_a_box   = (s0_type_a_q == SHAPE_BOX);

  logic signed [ExtBits-1:0] ac_x [3], bc_x [3], ah_x [3], bh_x [3];
  logic signed [ExtBits-1:0] a_min [3], a_max [3], b_min [3], b_max [3];
  logic signed [ExtBits-1:0] box_lo [3], box_hi [3], sph_c [3], clamped [3];
  logic signed [ExtBits-1:0] d_ext [3], ov_ext [3];
  logic [DistBits-1:0]       d1_d [3], ov1_d [3];
  logic [2:0]                sep1_d, neg1_d;
  logic [DistBits-1:0]       r1_d;
  logic [CoordBits-1:0]      sph_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ac_x[k] = {{2{s0_ac_q[k][CoordBits-1]}}, s0_ac_q[k]};
      bc_x[k] = {{2{s0_bc_q[k][CoordBits-1]}}, s0_bc_q[k]};
      ah_x[k] = {2'b00, s0_ah_q[k*CoordBits +: CoordBits]};
      bh_x[k] = {2'b00, s0_bh_q[k*CoordBits +: CoordBits]};

      a_min[k] = ac_x[k] - ah_x[k];
      a_max[k] = ac_x[k] + ah_x[k];
      b_min[k] = bc_x[k] - bh_x[k];
      b_max[k] = bc_x[k] + bh_x[k];

      // box-box: separation, overlap and sign of a minus b
      sep1_d[k] = (a_min[k] > b_max[k]) || (a_max[k] < b_min[k]);
      ov_ext[k] = ((a_max[k] < b_max[k]) ? a_max[k] : b_max[k])
                - ((a_min[k] > b_min[k]) ? a_min[k] : b_min[k]);
      ov1_d[k]  = ov_ext[k][DistBits-1:0];
      neg1_d[k] = (ac_x[k] < bc_x[k]);

      // box-sphere: clamp the sphere center into the box
      box_lo[k] = s0_a_box ? a_min[k] : b_min[k];
      box_hi[k] = s0_a_box ? a_max[k] : b_max[k];
      sph_c[k]  = s0_a_box ? bc_x[k] : ac_x[k];
      if (sph_c[k] < box_lo[k]) begin
        clamped[k] = box_lo[k];
      end else if (sph_c[k] > box_hi[k]) begin
        clamped[k] = box_hi[k];
      end else begin
        clamped[k] = sph_c[k];
      end

      // sphere-sphere uses the plain center difference
      d_ext[k] = s0_sph_sph ? (ac_x[k] - bc_x[k]) : (clamped[k] - sph_c[k]);
      d1_d[k]  = d_ext[k][DistBits-1:0];
    end

    sph_r = s0_a_box ? s0_bh_q[CoordBits-1:0] : s0_ah_q[CoordBits-1:0];
    if (s0_sph_sph) begin
      r1_d = {1'b0, s0_ah_q[CoordBits-1:0]} + {1'b0, s0_bh_q[CoordBits-1:0]};
    end else begin
      r1_d = {1'b0, sph_r};
    end
  end

  logic                s1_box_box_q;
  logic [DistBits-1:0] s1_d_q [3];
  logic [DistBits-1:0] s1_ov_q [3];
  logic [2:0]          s1_sep_q, s1_neg_q;
  logic [DistBits-1:0] s1_r_q;

  always_ff @(posedge clk_i) begin
    if (en1 && v0_q) begin
      s1_box_box_q <= s0_box_box;
      s1_d_q       <= d1_d;
      s1_ov_q      <= ov1_d;
      s1_sep_q     <= sep1_d;
      s1_neg_q     <= neg1_d;
      s1_r_q       <= r1_d;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: squares, box-box axis selection (ties to x, then y)
  // ---------------------------------------------------------------------
  logic signed [SqBits-1:0] prod [3];
  logic [SqBits-1:0]        sq2_d [3];
  logic [SqBits-1:0]        rsq2_d;
  axis_e                    axis2_d;
  logic [DistBits-1:0]      pen2_d;
  logic                     neg2_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k]  = SqBits'($signed(s1_d_q[k])) * SqBits'($signed(s1_d_q[k]));
      sq2_d[k] = unsigned'(prod[k]);
    end
    rsq2_d = SqBits'(s1_r_q) * SqBits'(s1_r_q);

    if ((s1_ov_q[0] <= s1_ov_q[1]) && (s1_ov_q[0] <= s1_ov_q[2])) begin
      axis2_d = AXIS_X;
      pen2_d  = s1_ov_q[0];
      neg2_d  = s1_neg_q[0];
    end else if (s1_ov_q[1] <= s1_ov_q[2]) begin
      axis2_d = AXIS_Y;
      pen2_d  = s1_ov_q[1];
      neg2_d  = s1_neg_q[1];
    end else begin
      axis2_d = AXIS_Z;
      pen2_d  = s1_ov_q[2];
      neg2_d  = s1_neg_q[2];
    end
  end

  logic                s2_box_box_q, s2_bb_hit_q;
  logic [SqBits-1:0]   s2_sq_q [3];
  logic [SqBits-1:0]   s2_rsq_q;
  axis_e               s2_axis_q;
  logic [DistBits-1:0] s2_pen_q;
  logic                s2_neg_q;

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      s2_box_box_q <= s1_box_box_q;
      s2_bb_hit_q  <= (s1_sep_q == 3'b000);
      s2_sq_q      <= sq2_d;
      s2_rsq_q     <= rsq2_d;
      s2_axis_q    <= axis2_d;
      s2_pen_q     <= pen2_d;
      s2_neg_q     <= neg2_d;
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: sum of squares against squared radius, output register
  // ---------------------------------------------------------------------
  logic [SqBits-1:0]   dsum;
  logic                bb_hit;
  logic                hit3_d;
  axis_e               axis3_d;
  logic [DistBits-1:0] pen3_d;
  logic                neg3_d;

  always_comb begin
    // three squares of at most 2^(2*CoordBits) still fit SqBits
    dsum   = s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];
    bb_hit = s2_box_box_q && s2_bb_hit_q;
    if (s2_box_box_q) begin
      hit3_d = s2_bb_hit_q;
    end else begin
      hit3_d = (dsum <= s2_rsq_q);
    end
    axis3_d = bb_hit ? s2_axis_q : AXIS_NONE;
    pen3_d  = bb_hit ? s2_pen_q : '0;
    neg3_d  = bb_hit && s2_neg_q;
  end

  axis_e axis_q;

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      hit_o             <= hit3_d;
      penetration_o     <= pen3_d;
      axis_q            <= axis3_d;
      normal_negative_o <= neg3_d;
    end
  end

  assign normal_axis_o = axis_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // an axis is only reported together with a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (normal_axis_o != AXIS_NONE) |-> hit_o)
    else $error("normal axis reported without a hit");

  // no axis means no penetration and no sign
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (normal_axis_o == AXIS_NONE)
      |-> (penetration_o == '0) && !normal_negative_o)
    else $error("penetration or sign without a normal axis");

  // back pressure reaches the input only once every stage holds a pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v0_q && v1_q && v2_q && v3_q)
    else $error("input stalled while the pipeline has a bubble");

  // an accepted transaction lands in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v0_q)
    else $error("accepted transaction lost at the input register");

  // a result moves out or stays, the pipeline never drops it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !en3 |=> v2_q && v3_q)
    else $error("stalled pipeline lost a pair");

endmodule
